FILE: src/circular_queue_with_reverse_macros.svh
// Assertion macros shared by the checker of the circular queue block.
`ifndef CIRCULAR_QUEUE_WITH_REVERSE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_REVERSE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define CQR_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define CQR_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/cqr_pkg.sv
// Shared constants, operation codes and control types of the circular queue block.
package cqr_pkg;

  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int OCC_W       = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - OCC_W;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REV = 2'd2;

  typedef struct packed {
    logic enq;
    logic deq_empty;
    logic nop;
    logic deq_start;
    logic deq_finish;
    logic rev_start;
    logic drain;
    logic fill_start;
    logic fill;
    logic rev_finish;
  } cqr_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic drain_done;
    logic fill_done;
    logic out_busy;
  } cqr_status_t;

endpackage

FILE: src/cqr_ctrl.sv
// Controller state machine that sequences enqueue, dequeue and reverse operations.
module cqr_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [cqr_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  cqr_pkg::cqr_status_t     status,
  output cqr_pkg::cqr_cmd_t        cmd
);
  import cqr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEQ   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // A new transaction is taken only when the result slot is free at this edge.
        in_ready = !status.out_busy;
        if (in_valid && !status.out_busy) begin
          unique case (in_op)
            OP_ENQ: begin
              cmd.enq = 1'b1;
            end
            OP_DEQ: begin
              if (status.empty) begin
                cmd.deq_empty = 1'b1;
              end else begin
                cmd.deq_start = 1'b1;
                state_next    = ST_DEQ;
              end
            end
            OP_REV: begin
              cmd.rev_start = 1'b1;
              state_next    = ST_DRAIN;
            end
            default: begin
              cmd.nop = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ: begin
        cmd.deq_finish = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_DRAIN: begin
        if (status.drain_done) begin
          cmd.fill_start = 1'b1;
          state_next     = ST_FILL;
        end else begin
          cmd.drain = 1'b1;
        end
      end
      ST_FILL: begin
        if (status.fill_done) begin
          cmd.rev_finish = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.fill = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/cqr_dp.sv
// Datapath: queue and stack memories, pointers, counters and the result register.
module cqr_dp #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cqr_pkg::cqr_cmd_t                  cmd,
  output cqr_pkg::cqr_status_t               status,
  input  logic signed [cqr_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cqr_pkg::VALUE_W-1:0] out_data,
  output logic                               out_ok,
  output logic [cqr_pkg::OCC_W-1:0]          out_occ
);
  import cqr_pkg::*;

  localparam int QA_W  = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int SC_W  = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (QC_W > SC_W) ? QC_W : SC_W;
  localparam int EXT_W = (QC_W > OCC_W) ? QC_W : OCC_W;

  localparam logic [QA_W-1:0]  QLAST  = QA_W'(QUEUE_DEPTH - 1);
  localparam logic [QC_W-1:0]  QFULL  = QC_W'(QUEUE_DEPTH);
  localparam logic [CMP_W-1:0] SLIMIT = CMP_W'(STACK_DEPTH);
  localparam logic [SC_W-1:0]  SFULL  = SC_W'(STACK_DEPTH);

  logic signed [VALUE_W-1:0] queue_mem [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] stack_mem [STACK_DEPTH];

  logic [QA_W-1:0] head;
  logic [QA_W-1:0] tail;
  logic [QC_W-1:0] count;
  logic [SC_W-1:0] sp;
  logic [SC_W-1:0] rem;
  logic            pend;

  logic signed [VALUE_W-1:0] q_rdata;
  logic signed [VALUE_W-1:0] s_rdata;

  logic [QA_W-1:0]           head_inc;
  logic [QA_W-1:0]           tail_inc;
  logic [SC_W-1:0]           sp_m1;
  logic [SC_W-1:0]           kept;
  logic                      enq_ok;
  logic                      q_we;
  logic signed [VALUE_W-1:0] q_wdata;
  logic                      s_we;
  logic                      load_out;
  logic [QC_W-1:0]           occ_cnt;
  logic [EXT_W-1:0]          occ_ext;

  assign status.empty      = (count == '0);
  assign status.full       = (count == QFULL);
  assign status.drain_done = (rem == '0) && !pend;
  assign status.fill_done  = (sp == '0) && !pend;
  assign status.out_busy   = out_valid && !out_ready;

  assign head_inc = (head == QLAST) ? '0 : head + 1'b1;
  assign tail_inc = (tail == QLAST) ? '0 : tail + 1'b1;
  assign sp_m1    = sp - 1'b1;

  // Only the words that fit on the stack are moved; the rest are dropped.
  assign kept = (CMP_W'(count) < SLIMIT) ? SC_W'(count) : SFULL;

  assign enq_ok   = cmd.enq && !status.full;
  assign q_we     = enq_ok || (cmd.fill && pend);
  assign q_wdata  = cmd.enq ? in_value : s_rdata;
  assign s_we     = cmd.drain && pend;
  assign load_out = cmd.enq || cmd.deq_empty || cmd.nop || cmd.deq_finish || cmd.rev_finish;
  assign occ_cnt  = enq_ok ? count + 1'b1 : count;
  assign occ_ext  = EXT_W'(occ_cnt);

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail] <= q_wdata;
    end
    q_rdata <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[sp[SA_W-1:0]] <= q_rdata;
    end
    s_rdata <= stack_mem[sp_m1[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      sp        <= '0;
      rem       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (enq_ok) begin
        tail  <= tail_inc;
        count <= count + 1'b1;
      end
      if (cmd.deq_start) begin
        count <= count - 1'b1;
        if (count == QC_W'(1)) begin
          head <= '0;
          tail <= '0;
        end else begin
          head <= head_inc;
        end
      end
      if (cmd.rev_start) begin
        rem  <= kept;
        sp   <= '0;
        pend <= 1'b0;
      end
      // Drain: the word read at the head lands on the stack in the next cycle.
      if (cmd.drain) begin
        pend <= (rem != '0);
        if (rem != '0) begin
          head <= head_inc;
          rem  <= rem - 1'b1;
        end
        if (pend) begin
          sp <= sp + 1'b1;
        end
      end
      if (cmd.fill_start) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
        pend  <= 1'b0;
      end
      // Fill: the word popped from the stack is written to the queue in the next cycle.
      if (cmd.fill) begin
        pend <= (sp != '0);
        if (sp != '0) begin
          sp <= sp_m1;
        end
        if (pend) begin
          tail  <= tail_inc;
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cmd.deq_finish) begin
        out_data <= q_rdata;
      end else if (cmd.deq_empty) begin
        out_data <= '1;
      end else begin
        out_data <= '0;
      end
      out_ok  <= enq_ok || cmd.deq_finish || cmd.rev_finish;
      out_occ <= occ_ext[OCC_W-1:0];
    end
  end

endmodule

FILE: src/circular_queue_with_reverse.sv
// Top level of the circular queue with order reversal through a stack.
//
// Input channel s_axis: one transaction per operation. s_axis_tuser carries the
// operation (enqueue, dequeue, reverse) and s_axis_tdata the word to enqueue.
// Output channel m_axis: exactly one result transaction per operation, in order.
// m_axis_tdata carries the dequeued word and the occupancy after the operation,
// m_axis_tuser the success flag.
// Enqueue, an empty dequeue and the unused code complete at the accepting edge:
// the result is valid in the next cycle and, while results are taken, a new
// operation can be taken every cycle. A dequeue with data first passes through
// a dequeue state, because the read of the queue memory is registered. A reverse
// drains min(occupancy, STACK_DEPTH) words into the stack memory, one word per
// cycle, and then fills them back from it, one word per cycle.
// The result register parts the two sides: the next operation is accepted in
// the same cycle as the previous result is taken. While m_axis_tready is low and
// a result is waiting, s_axis_tready stays low and the result holds.
// Synchronous reset empties the queue and the stack and drops any pending result.
// The memories are not cleared; no entry is read before it is written.
module circular_queue_with_reverse #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cqr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] value
  input  logic [cqr_pkg::OP_W-1:0]           s_axis_tuser,  // [1:0] op
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cqr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] data_out, [42:32] occupancy
  output logic [0:0]                         m_axis_tuser   // [0] ok
);
  import cqr_pkg::*;

  cqr_cmd_t                  cmd;
  cqr_status_t               status;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [VALUE_W-1:0] out_data;
  logic                      out_ok;
  logic [OCC_W-1:0]          out_occ;

  assign in_value = $signed(s_axis_tdata[VALUE_W-1:0]);

  cqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cqr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_value  (in_value),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .out_ok    (out_ok),
    .out_occ   (out_occ)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_occ, out_data};
  assign m_axis_tuser = out_ok;

endmodule

FILE: src/cqr_checker.sv
// Port-level checker of the circular queue block and its bind to the top level.
`include "circular_queue_with_reverse_macros.svh"

module cqr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [cqr_pkg::OP_W-1:0]        s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cqr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);
  import cqr_pkg::*;

  logic                   out_stall;
  logic                   out_fail;
  logic                   in_take;
  logic [VALUE_W-1:0]     out_word;
  logic [OCC_W-1:0]       out_count;
  logic [OUT_TDATA_W:0]   out_all;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_fail  = m_axis_tvalid && !m_axis_tuser[0];
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_word  = m_axis_tdata[VALUE_W-1:0];
  assign out_count = m_axis_tdata[VALUE_W +: OCC_W];
  assign out_all   = {m_axis_tuser, m_axis_tdata};

  // A stalled result keeps its transaction unchanged.
  `CQR_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_all), "stalled result changed")

  // A failed operation reports either zero or the empty-dequeue marker.
  `CQR_ASSERT_IMP(a_fail_data, out_fail, out_word == '0 || out_word == '1, "failed result carries data")

  // The empty-dequeue marker comes only with an empty queue.
  `CQR_ASSERT_IMP(a_empty_occ, out_fail && out_word == '1, out_count == '0, "empty dequeue not empty")

  // An accepted enqueue produces its result in the next cycle.
  `CQR_ASSERT_NXT(a_enq_latency, in_take && s_axis_tuser == OP_ENQ, m_axis_tvalid, "enqueue result late")

  // No new operation is taken while a result is stalled.
  `CQR_ASSERT_IMP(a_no_accept_stalled, out_stall, !s_axis_tready, "input taken while result stalled")

endmodule

bind circular_queue_with_reverse cqr_checker u_cqr_checker (.*);

FILE: sim/circular_queue_with_reverse_tb.sv
// Self-checking testbench for the circular queue with order reversal through a stack.
module circular_queue_with_reverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cqr_pkg::*;

  localparam int QUEUE_DEPTH = 1024;
  localparam int STACK_DEPTH = 1024;
  localparam int RANDOM_ITEMS = 250;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [VALUE_W-1:0] data;
    logic               ok;
    logic [OCC_W-1:0]   occ;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [31:0] value
  logic [OP_W-1:0]        s_axis_tuser;   // [1:0] op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] data_out, [42:32] occupancy
  logic [0:0]             m_axis_tuser;   // [0] ok

  // Contents of the queue as the block should hold them, head first.
  logic [VALUE_W-1:0] held_words[$];
  outcome_t           pending_results[$];
  int unsigned        failures = 0;
  int unsigned        cycles = 0;
  bit                 sink_steady = 1'b0;
  bit                 sink_hold_req = 1'b0;
  bit                 source_steady = 1'b0;

  circular_queue_with_reverse #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic outcome_t predict_queue_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    outcome_t           r;
    logic [VALUE_W-1:0] stacked[$];
    logic [VALUE_W-1:0] w;
    r.data = '0;
    r.ok = 1'b0;
    case (op)
      OP_ENQ: begin
        if (held_words.size() < QUEUE_DEPTH) begin
          held_words.push_back(value);
          r.ok = 1'b1;
        end
      end
      OP_DEQ: begin
        if (held_words.size() > 0) begin
          r.data = held_words.pop_front();
          r.ok = 1'b1;
        end else begin
          r.data = '1;
        end
      end
      OP_REV: begin
        // Words beyond the stack depth are lost during the drain.
        while (held_words.size() > 0) begin
          w = held_words.pop_front();
          if (stacked.size() < STACK_DEPTH) stacked.push_back(w);
        end
        while (stacked.size() > 0) held_words.push_back(stacked.pop_back());
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.occ = OCC_W'(held_words.size());
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic push_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tuser <= op;
    do @(negedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_queue_op(op, value));
    @(posedge clk);
  endtask

  task automatic pause_source(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic push_with_gap(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    if (!source_steady && $urandom_range(0, 3) == 0) pause_source(pick_gap());
    push_item(op, value);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_directed_edges();
    push_with_gap(OP_DEQ, $urandom);
    push_with_gap(OP_REV, $urandom);
    push_with_gap(OP_UNUSED, 32'hffff_ffff);
    push_with_gap(OP_ENQ, 32'h8000_0000);
    push_with_gap(OP_ENQ, 32'h7fff_ffff);
    push_with_gap(OP_ENQ, 32'hffff_ffff);
    push_with_gap(OP_ENQ, 32'h0000_0000);
    push_with_gap(OP_ENQ, 32'h0000_0001);
    push_with_gap(OP_ENQ, 32'h5555_aaaa);
    push_with_gap(OP_UNUSED, 32'haaaa_5555);
    push_with_gap(OP_REV, $urandom);
    push_with_gap(OP_DEQ, $urandom);
    push_with_gap(OP_DEQ, $urandom);
    push_with_gap(OP_REV, $urandom);
    repeat (4) push_with_gap(OP_DEQ, $urandom);
    push_with_gap(OP_DEQ, $urandom);
    push_with_gap(OP_ENQ, 32'h1234_5678);
    push_with_gap(OP_REV, $urandom);
    push_with_gap(OP_DEQ, $urandom);
    push_with_gap(OP_DEQ, $urandom);
    wait_results_drained();
  endtask

  // Fills the queue to capacity, overflows it, then reverses it full and again wrapped.
  task automatic test_full_queue();
    while (held_words.size() < QUEUE_DEPTH) push_with_gap(OP_ENQ, $urandom);
    repeat (3) push_with_gap(OP_ENQ, $urandom);
    push_with_gap(OP_REV, $urandom);
    repeat (100) push_with_gap(OP_DEQ, $urandom);
    repeat (60) push_with_gap(OP_ENQ, $urandom);
    push_with_gap(OP_REV, $urandom);
    push_with_gap(OP_UNUSED, $urandom);
    wait_results_drained();
  endtask

  task automatic test_receiver_hold();
    source_steady = 1'b1;
    sink_hold_req = 1'b1;
    repeat (40) push_item(logic'($urandom_range(0, 1)) ? OP_ENQ : OP_DEQ, $urandom);
    push_item(OP_REV, $urandom);
    source_steady = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    int unsigned sent;
    int unsigned burst;
    int unsigned bias;
    int unsigned roll;
    int unsigned enq_share;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(10, 60);
      bias = $urandom_range(0, 2);
      enq_share = (bias == 0) ? 75 : (bias == 1) ? 53 : 30;
      source_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) op = OP_REV;
        else if (roll < 7) op = OP_UNUSED;
        else if (roll < enq_share) op = OP_ENQ;
        else op = OP_DEQ;
        push_with_gap(op, $urandom);
        sent++;
      end
      // Now and then let every result come back before going on.
      if ($urandom_range(0, 5) == 0) wait_results_drained();
    end
    source_steady = 1'b0;
    sink_steady = 1'b0;
    wait_results_drained();
  endtask

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Handshake signals are stable at the falling edge, so a transaction seen
  // here completes at the next rising edge.
  initial begin : result_check
    outcome_t           want;
    logic [VALUE_W-1:0] got_data;
    logic [OCC_W-1:0]   got_occ;
    logic               got_ok;
    forever begin
      @(negedge clk);
      if (rst !== 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got_data = m_axis_tdata[VALUE_W-1:0];
        got_occ = m_axis_tdata[VALUE_W +: OCC_W];
        got_ok = m_axis_tuser[0];
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("unexpected result: data_out %h ok %b occupancy %0d",
                     got_data, got_ok, got_occ);
        end else begin
          want = pending_results.pop_front();
          if (got_data !== want.data || got_ok !== want.ok || got_occ !== want.occ) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("mismatch: expected data_out %h ok %b occupancy %0d, got %h %b %0d",
                       want.data, want.ok, want.occ, got_data, got_ok, got_occ);
          end
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_ENQ;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_full_queue();
    test_receiver_hold();
    test_random_mix();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) failures++;
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: circular_queue_with_reverse.f
+incdir+src
src/cqr_pkg.sv
src/cqr_ctrl.sv
src/cqr_dp.sv
src/circular_queue_with_reverse.sv
src/cqr_checker.sv
sim/circular_queue_with_reverse_tb.sv
